### rtl/srrip_pkg.sv
// Shared types and constants for the SRRIP set-associative cache lookup.
// No dependencies; every other file of the block but srrip_ram imports this package.
package srrip_pkg;

  localparam int ADDR_W    = 32;
  localparam int CNT_W     = 32;
  localparam int WAY_OUT_W = 2;
  localparam int RRPV_W    = 2;

  localparam logic [RRPV_W-1:0] RRPV_MAX  = 2'd3;
  localparam logic [RRPV_W-1:0] RRPV_FILL = 2'd2;
  localparam logic [RRPV_W-1:0] RRPV_HIT  = 2'd0;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic capture;
    logic evaluate;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic out_stall;
  } ctl_sts_t;

endpackage

### rtl/srrip_ifs.sv
// Valid/ready channel interfaces for access words and result words.
// Depends on srrip_pkg for field widths.
interface srrip_in_if;
  import srrip_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;
  logic              opcode;

  modport source (output valid, output address, output opcode, input ready);
  modport sink   (input valid, input address, input opcode, output ready);
endinterface

interface srrip_out_if;
  import srrip_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 is_hit;
  logic [WAY_OUT_W-1:0] way_used;
  logic                 writeback_needed;
  logic [CNT_W-1:0]     hit_total;
  logic [CNT_W-1:0]     miss_total;

  modport source (output valid, output is_hit, output way_used, output writeback_needed,
                  output hit_total, output miss_total, input ready);
  modport sink   (input valid, input is_hit, input way_used, input writeback_needed,
                  input hit_total, input miss_total, output ready);
endinterface

### rtl/srrip_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srrip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/srrip_ctrl.sv
// Sequencer for the SRRIP lookup: clearing pass, accept, evaluate.
// Depends on srrip_pkg for the command and status structs.
module srrip_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  srrip_pkg::ctl_sts_t sts,
  output srrip_pkg::ctl_cmd_t cmd
);
  import srrip_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt      = state_r;
    cmd.clear_step = 1'b0;
    cmd.capture    = 1'b0;
    cmd.evaluate   = 1'b0;
    in_ready       = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // hold until the result register is free
        if (!sts.out_stall) begin
          cmd.evaluate = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/srrip_dpath.sv
// Datapath for the SRRIP lookup: set-row RAM, hit search, victim choice,
// aging, counters and result register. Depends on srrip_pkg and srrip_ram.
module srrip_dpath #(
  parameter int NUM_SETS   = 256,
  parameter int NUM_WAYS   = 4,
  parameter int LINE_BYTES = 64
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  srrip_pkg::ctl_cmd_t                     cmd,
  output srrip_pkg::ctl_sts_t                     sts,
  input  logic [srrip_pkg::ADDR_W-1:0]            in_address,
  input  logic                                    in_opcode,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    out_is_hit,
  output logic [srrip_pkg::WAY_OUT_W-1:0]         out_way_used,
  output logic                                    out_writeback_needed,
  output logic [srrip_pkg::CNT_W-1:0]             out_hit_total,
  output logic [srrip_pkg::CNT_W-1:0]             out_miss_total
);
  import srrip_pkg::*;

  localparam int OFF_W    = $clog2(LINE_BYTES);
  localparam int SET_BITS = $clog2(NUM_SETS);
  localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int TAG_W    = ADDR_W - OFF_W - SET_BITS;
  localparam int WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  // way entry: {tag, valid, dirty, rrpv}
  localparam int ENT_W    = TAG_W + 2 + RRPV_W;
  localparam int ROW_W    = NUM_WAYS * ENT_W;
  localparam int DIRTY_B  = RRPV_W;
  localparam int VALID_B  = RRPV_W + 1;
  localparam int TAG_B    = RRPV_W + 2;

  logic [SET_W-1:0] in_set;
  logic [SET_W-1:0] set_r;
  logic [TAG_W-1:0] tag_r;
  logic             op_r;
  logic [SET_W-1:0] clr_cnt_r;
  logic [SET_W-1:0] clr_cnt_nxt;
  logic [CNT_W-1:0] hit_cnt_r;
  logic [CNT_W-1:0] hit_cnt_nxt;
  logic [CNT_W-1:0] miss_cnt_r;
  logic [CNT_W-1:0] miss_cnt_nxt;
  logic             out_valid_r;
  logic             is_hit_r;
  logic [WAY_OUT_W-1:0] way_r;
  logic             wb_r;

  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] row_rd;
  logic [ROW_W-1:0] row_nxt;

  logic [RRPV_W-1:0] rrpv   [NUM_WAYS];
  logic [NUM_WAYS-1:0] match;
  logic              hit;
  logic [WAY_W-1:0]  hit_way;
  logic [WAY_W-1:0]  vic_way;
  logic [WAY_W-1:0]  way_sel;
  logic              any3;
  logic              any2;
  logic              any1;
  logic [RRPV_W-1:0] top;
  logic [RRPV_W-1:0] age_add;
  logic              wb;

  assign in_set = (SET_BITS > 0) ? in_address[OFF_W +: SET_W] : '0;

  srrip_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.capture),
    .raddr (in_set),
    .rdata (row_rd)
  );

  // search, victim choice, aging and updated set row
  always_comb begin
    match   = '0;
    any3    = 1'b0;
    any2    = 1'b0;
    any1    = 1'b0;
    hit_way = '0;
    vic_way = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      rrpv[w]  = row_rd[w*ENT_W +: RRPV_W];
      match[w] = row_rd[w*ENT_W + VALID_B] &&
                 (row_rd[w*ENT_W + TAG_B +: TAG_W] == tag_r);
      any3 = any3 | (rrpv[w] == 2'd3);
      any2 = any2 | (rrpv[w] == 2'd2);
      any1 = any1 | (rrpv[w] == 2'd1);
    end
    hit = |match;
    top = any3 ? 2'd3 : (any2 ? 2'd2 : (any1 ? 2'd1 : 2'd0));
    age_add = RRPV_MAX - top;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
      if (rrpv[w] == top) begin
        vic_way = WAY_W'(w);
      end
    end
    way_sel = hit ? hit_way : vic_way;
    wb = 1'b0;
    row_nxt = row_rd;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (hit) begin
        if (WAY_W'(w) == hit_way) begin
          row_nxt[w*ENT_W +: RRPV_W] = RRPV_HIT;
          row_nxt[w*ENT_W + DIRTY_B] = row_rd[w*ENT_W + DIRTY_B] | (op_r == OP_WRITE);
        end
      end else if (WAY_W'(w) == vic_way) begin
        wb = row_rd[w*ENT_W + VALID_B] & row_rd[w*ENT_W + DIRTY_B];
        row_nxt[w*ENT_W +: ENT_W] = {tag_r, 1'b1, (op_r == OP_WRITE), RRPV_FILL};
      end else begin
        row_nxt[w*ENT_W +: RRPV_W] = rrpv[w] + age_add;
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = set_r;
    ram_wdata = row_nxt;
    if (cmd.clear_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else if (cmd.evaluate) begin
      ram_we = 1'b1;
    end
  end

  assign clr_cnt_nxt  = clr_cnt_r + SET_W'(1);
  assign hit_cnt_nxt  = hit_cnt_r + CNT_W'(hit);
  assign miss_cnt_nxt = miss_cnt_r + CNT_W'(!hit);

  assign sts.clear_last = (clr_cnt_r == SET_W'(NUM_SETS - 1));
  assign sts.out_stall  = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clr_cnt_r <= clr_cnt_nxt;
      end
      if (cmd.evaluate) begin
        hit_cnt_r   <= hit_cnt_nxt;
        miss_cnt_r  <= miss_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      set_r <= in_set;
      tag_r <= in_address[ADDR_W-1 -: TAG_W];
      op_r  <= in_opcode;
    end
    if (cmd.evaluate) begin
      is_hit_r <= hit;
      way_r    <= WAY_OUT_W'(32'(way_sel));
      wb_r     <= !hit && wb;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_is_hit           = is_hit_r;
  assign out_way_used         = way_r;
  assign out_writeback_needed = wb_r;
  assign out_hit_total        = hit_cnt_r;
  assign out_miss_total       = miss_cnt_r;

endmodule

### rtl/srrip_set_assoc_cache_lookup_core.sv
// SRRIP set-associative cache lookup, top level: sequencer plus datapath.
// Depends on srrip_pkg, srrip_ifs, srrip_ctrl and srrip_dpath.
//
// Each access word is accepted and its set row is read from the row RAM;
// then the registered row is searched, the updated row is written back and
// the result word is loaded into the output register. A new access word is
// accepted only after the previous one is evaluated; a result that waits in
// the output register holds the evaluation of the following access. After
// reset a clearing pass writes every set row, with in ready low. Way numbers
// are given modulo 4; counters wrap at 2^32.
module srrip_set_assoc_cache_lookup_core #(
  parameter int NUM_SETS   = 256,
  parameter int NUM_WAYS   = 4,
  parameter int LINE_BYTES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  srrip_in_if.sink           in_port,
  srrip_out_if.source        out_port
);
  import srrip_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  srrip_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_port.valid),
    .in_ready (in_port.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  srrip_dpath #(
    .NUM_SETS   (NUM_SETS),
    .NUM_WAYS   (NUM_WAYS),
    .LINE_BYTES (LINE_BYTES)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_address           (in_port.address),
    .in_opcode            (in_port.opcode),
    .out_valid            (out_port.valid),
    .out_ready            (out_port.ready),
    .out_is_hit           (out_port.is_hit),
    .out_way_used         (out_port.way_used),
    .out_writeback_needed (out_port.writeback_needed),
    .out_hit_total        (out_port.hit_total),
    .out_miss_total       (out_port.miss_total)
  );

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for srrip_set_assoc_cache_lookup_core: access words go in,
// result words are checked against an in-bench SRRIP tag/re-reference predictor.
// Depends on srrip_pkg and the channel interfaces in srrip_ifs.
module testbench;
  import srrip_pkg::*;

  localparam int SETS  = 256;
  localparam int WAYS  = 4;
  localparam int OFF_W = 6;
  localparam int SET_W = 8;
  localparam int TAG_W = ADDR_W - OFF_W - SET_W;
  localparam int RANDOM_WORDS = 1750;

  typedef struct {
    logic [ADDR_W-1:0] address;
    logic              opcode;
    bit                drain;
  } access_word_t;

  typedef struct packed {
    logic                 is_hit;
    logic [WAY_OUT_W-1:0] way_used;
    logic                 writeback_needed;
    logic [CNT_W-1:0]     hit_total;
    logic [CNT_W-1:0]     miss_total;
  } lookup_word_t;

  logic clk;
  logic rst_n;

  srrip_in_if  in_if ();
  srrip_out_if out_if ();

  srrip_set_assoc_cache_lookup_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_if),
    .out_port (out_if)
  );

  access_word_t access_q[$];
  lookup_word_t lookup_q[$];
  access_word_t cur_access;
  int           words_sent;
  int           total_words;
  int           errors;

  logic [TAG_W-1:0]  line_tag   [SETS*WAYS];
  bit                line_valid [SETS*WAYS];
  bit                line_dirty [SETS*WAYS];
  logic [RRPV_W-1:0] line_rrpv  [SETS*WAYS];
  logic [CNT_W-1:0]  hit_count;
  logic [CNT_W-1:0]  miss_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic lookup_word_t lookup_predict(input logic [ADDR_W-1:0] addr,
                                                  input logic op);
    lookup_word_t     w;
    logic [TAG_W-1:0] tag;
    int               base;
    int               way;
    int               top;
    bit               hit;
    bit               found;
    tag  = addr[ADDR_W-1 -: TAG_W];
    base = int'(addr[OFF_W +: SET_W]) * WAYS;
    hit  = 1'b0;
    way  = 0;
    for (int i = 0; i < WAYS; i++) begin
      if (!hit && line_valid[base+i] && line_tag[base+i] == tag) begin
        hit = 1'b1;
        way = i;
      end
    end
    w.writeback_needed = 1'b0;
    if (hit) begin
      hit_count = hit_count + 1;
      line_rrpv[base+way] = RRPV_HIT;
      if (op == OP_WRITE) line_dirty[base+way] = 1'b1;
    end else begin
      miss_count = miss_count + 1;
      top = 0;
      for (int i = 0; i < WAYS; i++)
        if (int'(line_rrpv[base+i]) > top) top = int'(line_rrpv[base+i]);
      // age the whole set until some way reaches the distant value
      if (top < int'(RRPV_MAX))
        for (int i = 0; i < WAYS; i++)
          line_rrpv[base+i] = line_rrpv[base+i] + RRPV_W'(int'(RRPV_MAX) - top);
      found = 1'b0;
      for (int i = 0; i < WAYS; i++) begin
        if (!found && line_rrpv[base+i] == RRPV_MAX) begin
          found = 1'b1;
          way   = i;
        end
      end
      w.writeback_needed = line_valid[base+way] && line_dirty[base+way];
      line_tag[base+way]   = tag;
      line_valid[base+way] = 1'b1;
      line_dirty[base+way] = (op == OP_WRITE);
      line_rrpv[base+way]  = RRPV_FILL;
    end
    w.is_hit     = hit;
    w.way_used   = WAY_OUT_W'(way);
    w.hit_total  = hit_count;
    w.miss_total = miss_count;
    return w;
  endfunction

  function automatic int idle_share(input bit sender);
    int phase;
    phase = (words_sent * 3 < total_words) ? 0 : (words_sent * 3 < 2 * total_words) ? 1 : 2;
    if (phase == 0) return sender ? 36 : 60;
    if (phase == 1) return sender ? 60 : 36;
    return 0;
  endfunction

  function automatic logic [ADDR_W-1:0] make_addr(input logic [TAG_W-1:0] tag,
                                                  input logic [SET_W-1:0] set_idx,
                                                  input logic [OFF_W-1:0] offset);
    return {tag, set_idx, offset};
  endfunction

  task automatic add_access(input logic [ADDR_W-1:0] addr, input logic op,
                            input bit drain);
    access_word_t a;
    a.address = addr;
    a.opcode  = op;
    a.drain   = drain;
    access_q.push_back(a);
  endtask

  // driver: hold the word until accepted, then predict and offer the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        lookup_q.push_back(lookup_predict(cur_access.address, cur_access.opcode));
        words_sent++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (access_q.size() > 0 && $urandom_range(0, 99) >= idle_share(1'b1) &&
            (!access_q[0].drain || lookup_q.size() == 0)) begin
          cur_access = access_q.pop_front();
          in_if.address <= cur_access.address;
          in_if.opcode  <= cur_access.opcode;
          in_if.valid   <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= idle_share(1'b0));
    end
  end

  // monitor: compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    lookup_word_t exp_w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (lookup_q.size() == 0) begin
        $error("result word with no access pending");
        errors++;
      end else begin
        exp_w = lookup_q.pop_front();
        if (out_if.is_hit !== exp_w.is_hit) begin
          $error("is_hit: expected %0d, actual %0d", exp_w.is_hit, out_if.is_hit);
          errors++;
        end
        if (out_if.way_used !== exp_w.way_used) begin
          $error("way_used: expected %0d, actual %0d", exp_w.way_used, out_if.way_used);
          errors++;
        end
        if (out_if.writeback_needed !== exp_w.writeback_needed) begin
          $error("writeback_needed: expected %0d, actual %0d",
                 exp_w.writeback_needed, out_if.writeback_needed);
          errors++;
        end
        if (out_if.hit_total !== exp_w.hit_total) begin
          $error("hit_total: expected %0d, actual %0d", exp_w.hit_total, out_if.hit_total);
          errors++;
        end
        if (out_if.miss_total !== exp_w.miss_total) begin
          $error("miss_total: expected %0d, actual %0d",
                 exp_w.miss_total, out_if.miss_total);
          errors++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [SET_W-1:0] hot_sets[8];
    logic [TAG_W-1:0] tag;
    logic [SET_W-1:0] set_idx;
    int               pick;
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.address = '0;
    in_if.opcode  = OP_READ;
    out_if.ready  = 1'b0;
    words_sent    = 0;
    errors        = 0;
    hit_count     = '0;
    miss_count    = '0;
    for (int i = 0; i < SETS * WAYS; i++) begin
      line_tag[i]   = '0;
      line_valid[i] = 1'b0;
      line_dirty[i] = 1'b0;
      line_rrpv[i]  = '0;
    end

    // directed: extremes, hits, write hits, aging and dirty evictions
    add_access(32'h0000_0000, OP_READ,  1'b0);
    add_access(32'h0000_003F, OP_READ,  1'b0);
    add_access(32'h0000_0010, OP_WRITE, 1'b0);
    add_access(32'hFFFF_FFFF, OP_WRITE, 1'b0);
    add_access(32'hFFFF_FFC0, OP_READ,  1'b0);
    add_access(make_addr(18'd1, 8'd0, 6'd5),  OP_READ,  1'b0);
    add_access(make_addr(18'd2, 8'd0, 6'd63), OP_WRITE, 1'b0);
    add_access(make_addr(18'd3, 8'd0, 6'd0),  OP_READ,  1'b0);
    add_access(make_addr(18'd4, 8'd0, 6'd1),  OP_READ,  1'b0);
    add_access(make_addr(18'd1, 8'd0, 6'd2),  OP_READ,  1'b0);
    add_access(make_addr(18'd0, 8'd0, 6'd3),  OP_WRITE, 1'b0);
    add_access(make_addr(18'd5, 8'd0, 6'd4),  OP_WRITE, 1'b1);
    add_access(make_addr(18'd6, 8'd0, 6'd4),  OP_READ,  1'b0);
    add_access(make_addr(18'd7, 8'd0, 6'd4),  OP_WRITE, 1'b0);
    add_access(make_addr(18'd5, 8'd0, 6'd4),  OP_READ,  1'b0);
    add_access(make_addr(18'h3FFFF, 8'd0, 6'd0),   OP_READ,  1'b0);
    add_access(make_addr(18'd0, 8'hFF, 6'd0),      OP_WRITE, 1'b0);
    add_access(make_addr(18'd1, 8'hFF, 6'd0),      OP_WRITE, 1'b0);
    add_access(make_addr(18'd2, 8'hFF, 6'd0),      OP_WRITE, 1'b0);
    add_access(make_addr(18'd3, 8'hFF, 6'd0),      OP_WRITE, 1'b0);
    add_access(make_addr(18'd4, 8'hFF, 6'd0),      OP_READ,  1'b0);
    add_access(32'hFFFF_FFFF, OP_READ,  1'b0);
    add_access(make_addr(18'h2AAAA, 8'h55, 6'h2A), OP_WRITE, 1'b0);
    add_access(make_addr(18'h15555, 8'hAA, 6'h15), OP_READ,  1'b0);

    // random: mostly a few hot sets with a small tag pool, some full-range noise
    hot_sets[0] = 8'h00;
    hot_sets[1] = 8'hFF;
    for (int i = 2; i < 8; i++) hot_sets[i] = SET_W'($urandom_range(0, SETS - 1));
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        tag     = ($urandom_range(0, 1) ? {TAG_W{1'b1}} : {TAG_W{1'b0}}) ^
                  TAG_W'($urandom_range(0, 5));
        set_idx = hot_sets[$urandom_range(0, 7)];
        add_access(make_addr(tag, set_idx, OFF_W'($urandom)), 1'($urandom),
                   (i == RANDOM_WORDS / 3) || (i == 2 * RANDOM_WORDS / 3));
      end else begin
        add_access($urandom, 1'($urandom), 1'b0);
      end
    end
    total_words = access_q.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (access_q.size() > 0 || in_if.valid) @(posedge clk);
    while (lookup_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/srrip_pkg.sv
rtl/srrip_ifs.sv
rtl/srrip_ram.sv
rtl/srrip_ctrl.sv
rtl/srrip_dpath.sv
rtl/srrip_set_assoc_cache_lookup_core.sv
tb/testbench.sv
